### rtl/core/agc_pkg.sv
// agc_pkg: shared widths, reset values, register indexes and the command and
// status structs between the controller and the datapath of the agc core
// no dependencies
package agc_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int PERIOD_W   = 16;
    localparam int NUM_W      = 27;
    localparam int SLOPE_W    = 16;
    localparam int OFFSET_W   = 20;
    localparam int DEN_W      = 27;
    localparam int CODE_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // default block length of the averager
    localparam int SAMPLES_PER_AVERAGE_DEF = 10;

    // one quotient bit per divider step
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PERIOD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SLOPE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OFFSET   = 3'd5;

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] KEY_PERIOD_RST    = 16'd20;
    localparam logic [PERIOD_W-1:0] GAIN_PERIOD_RST   = 16'd100;
    localparam logic [PERIOD_W-1:0] REPORT_PERIOD_RST = 16'd200;
    localparam logic [NUM_W-1:0]    GAIN_NUM_RST      = 27'd81920000;
    localparam logic [SLOPE_W-1:0]  GAIN_SLOPE_RST    = 16'd290;
    localparam logic [OFFSET_W-1:0] GAIN_OFFSET_RST   = 20'd19629;

    // commands from the controller, at most one per cycle
    typedef struct packed {
        logic capture;
        logic acc;
        logic avg_mul;
        logic avg_latch;
        logic gain_mul;
        logic den_load;
        logic div_step;
        logic gain_wr;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic gain_fire;
    } t_status;

endpackage

### rtl/core/agc_ctrl.sv
// agc_ctrl: sequencer of the agc core, steps one tick request through the
// datapath and owns the request handshakes; depends on agc_pkg
module agc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  agc_pkg::t_status  i_status,
    output agc_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_AVG_MUL,
        S_AVG_LATCH,
        S_GAIN_MUL,
        S_DEN,
        S_DIV,
        S_GAIN_WR,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [agc_pkg::STEP_W-1:0]    r_step;
    logic                          r_out_valid;
    logic                          w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:      o_cmd.capture   = i_in_valid;
            S_ACC:       o_cmd.acc       = 1'b1;
            S_AVG_MUL:   o_cmd.avg_mul   = 1'b1;
            S_AVG_LATCH: o_cmd.avg_latch = 1'b1;
            S_GAIN_MUL:  o_cmd.gain_mul  = 1'b1;
            S_DEN:       o_cmd.den_load  = 1'b1;
            S_DIV:       o_cmd.div_step  = 1'b1;
            S_GAIN_WR:   o_cmd.gain_wr   = 1'b1;
            S_DONE:      o_cmd.commit    = w_out_free;
            default:     o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC:       r_state <= S_AVG_MUL;
                S_AVG_MUL:   r_state <= S_AVG_LATCH;
                S_AVG_LATCH: begin
                    // gain path only on a gain tick
                    if (i_status.gain_fire) begin
                        r_state <= S_GAIN_MUL;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_GAIN_MUL:  r_state <= S_DEN;
                S_DEN: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == agc_pkg::STEP_W'(agc_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_GAIN_WR;
                    end else begin
                        r_step <= r_step + agc_pkg::STEP_W'(1);
                    end
                end
                S_GAIN_WR:   r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default:     r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/agc_dp.sv
// agc_dp: datapath of the agc core: registers, accumulators, period counters,
// averaging multiplier, gain multiplier and restoring divider; depends on agc_pkg
module agc_dp #(
    parameter int SAMPLES_PER_AVERAGE = agc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  agc_pkg::t_cmd                    i_cmd,
    output agc_pkg::t_status                 o_status,
    input  logic                             i_cfg_wr,
    input  logic [agc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [agc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [agc_pkg::SAMPLE_W-1:0]     i_level_sample,
    input  logic [agc_pkg::SAMPLE_W-1:0]     i_aux_sample,
    input  logic                             i_key_pressed,
    output logic [agc_pkg::SAMPLE_W-1:0]     o_level_average,
    output logic [agc_pkg::SAMPLE_W-1:0]     o_aux_average,
    output logic                             o_mode,
    output logic [agc_pkg::CODE_W-1:0]       o_gain_code,
    output logic                             o_gain_update,
    output logic                             o_report_strobe
);

    localparam int SW = agc_pkg::SAMPLE_W;
    localparam int PW = agc_pkg::PERIOD_W;
    localparam int NW = agc_pkg::NUM_W;
    localparam int DW = agc_pkg::DEN_W;
    localparam int CW = agc_pkg::CODE_W;

    // block sum and count widths
    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * ((1 << SW) - 1) + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_AVERAGE + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SAMPLES_PER_AVERAGE);

    // floor(sum / n) as (sum * ceil(2^sh / n)) >> sh, exact for every sum below 2^SUM_W
    localparam int SH     = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int M_W    = SUM_W + 2;
    localparam int RECIP  = ((1 << SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
    localparam int PROD_W = SUM_W + M_W;
    localparam int GP_W   = agc_pkg::SLOPE_W + SW;

    // configuration registers
    logic [PW-1:0]                  r_key_period;
    logic [PW-1:0]                  r_gain_period;
    logic [PW-1:0]                  r_report_period;
    logic [NW-1:0]                  r_gain_num;
    logic [agc_pkg::SLOPE_W-1:0]    r_gain_slope;
    logic [agc_pkg::OFFSET_W-1:0]   r_gain_offset;

    // captured request
    logic [SW-1:0]                  r_lvl_in;
    logic [SW-1:0]                  r_aux_in;
    logic                           r_key_in;

    // tick state
    logic [SUM_W-1:0]               r_lvl_sum;
    logic [SUM_W-1:0]               r_aux_sum;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_avg_due;
    logic [SW-1:0]                  r_lvl_avg;
    logic [SW-1:0]                  r_aux_avg;
    logic [PW-1:0]                  r_key_tick;
    logic [PW-1:0]                  r_gain_tick;
    logic [PW-1:0]                  r_rep_tick;
    logic                           r_key_prev;
    logic                           r_mode;
    logic [CW-1:0]                  r_gain_code;
    logic                           r_gain_fire;
    logic                           r_rep_fire;

    // arithmetic
    logic [PROD_W-1:0]              r_lvl_prod;
    logic [PROD_W-1:0]              r_aux_prod;
    logic [GP_W-1:0]                r_gprod;
    logic [DW-1:0]                  r_den;
    logic [DW-1:0]                  r_rem;
    logic [NW-1:0]                  r_quo;

    // result register
    logic [SW-1:0]                  r_out_lvl;
    logic [SW-1:0]                  r_out_aux;
    logic                           r_out_mode;
    logic [CW-1:0]                  r_out_code;
    logic                           r_out_gain_upd;
    logic                           r_out_rep;

    logic [SUM_W-1:0]               w_lvl_next;
    logic [SUM_W-1:0]               w_aux_next;
    logic [CNT_W-1:0]               w_cnt_next;
    logic [PW:0]                    w_key_tick;
    logic [PW:0]                    w_gain_tick;
    logic [PW:0]                    w_rep_tick;
    logic [DW:0]                    w_shift;
    logic [DW+1:0]                  w_diff;
    logic                           w_fits;
    logic [CW-1:0]                  w_code_sat;

    // period counter step: msb is the event, the rest the next count
    function automatic logic [PW:0] f_tick(input logic [PW-1:0] cnt,
                                           input logic [PW-1:0] period);
        logic [PW:0] nxt;
        nxt = {1'b0, cnt} + (PW+1)'(1);
        if (nxt >= {1'b0, period}) begin
            f_tick = {1'b1, {PW{1'b0}}};
        end else begin
            f_tick = {1'b0, nxt[PW-1:0]};
        end
    endfunction

    assign w_lvl_next  = r_lvl_sum + SUM_W'(r_lvl_in);
    assign w_aux_next  = r_aux_sum + SUM_W'(r_aux_in);
    assign w_cnt_next  = r_cnt + CNT_W'(1);
    assign w_key_tick  = f_tick(r_key_tick, r_key_period);
    assign w_gain_tick = f_tick(r_gain_tick, r_gain_period);
    assign w_rep_tick  = f_tick(r_rep_tick, r_report_period);

    // restoring divider step; a zero divisor gives all ones and so saturates
    assign w_shift    = {r_rem, r_quo[NW-1]};
    assign w_diff     = {1'b0, w_shift} - {2'b00, r_den};
    assign w_fits     = !w_diff[DW+1];
    assign w_code_sat = (|r_quo[NW-1:CW]) ? agc_pkg::CODE_MAX : r_quo[CW-1:0];

    assign o_status.gain_fire = r_gain_fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_period    <= agc_pkg::KEY_PERIOD_RST;
            r_gain_period   <= agc_pkg::GAIN_PERIOD_RST;
            r_report_period <= agc_pkg::REPORT_PERIOD_RST;
            r_gain_num      <= agc_pkg::GAIN_NUM_RST;
            r_gain_slope    <= agc_pkg::GAIN_SLOPE_RST;
            r_gain_offset   <= agc_pkg::GAIN_OFFSET_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                agc_pkg::CFG_KEY_PERIOD:    r_key_period    <= i_cfg_data[PW-1:0];
                agc_pkg::CFG_GAIN_PERIOD:   r_gain_period   <= i_cfg_data[PW-1:0];
                agc_pkg::CFG_REPORT_PERIOD: r_report_period <= i_cfg_data[PW-1:0];
                agc_pkg::CFG_GAIN_NUM:      r_gain_num      <= i_cfg_data[NW-1:0];
                agc_pkg::CFG_GAIN_SLOPE:
                    r_gain_slope  <= i_cfg_data[agc_pkg::SLOPE_W-1:0];
                agc_pkg::CFG_GAIN_OFFSET:
                    r_gain_offset <= i_cfg_data[agc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_sum   <= '0;
            r_aux_sum   <= '0;
            r_cnt       <= '0;
            r_avg_due   <= 1'b0;
            r_lvl_avg   <= '0;
            r_aux_avg   <= '0;
            r_key_tick  <= '0;
            r_gain_tick <= '0;
            r_rep_tick  <= '0;
            r_key_prev  <= 1'b0;
            r_mode      <= 1'b0;
            r_gain_code <= '0;
            r_gain_fire <= 1'b0;
            r_rep_fire  <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                r_lvl_sum   <= w_lvl_next;
                r_aux_sum   <= w_aux_next;
                r_avg_due   <= (w_cnt_next >= CNT_END);
                r_cnt       <= (w_cnt_next >= CNT_END) ? '0 : w_cnt_next;
                r_rep_tick  <= w_rep_tick[PW-1:0];
                r_rep_fire  <= w_rep_tick[PW];
                r_gain_tick <= w_gain_tick[PW-1:0];
                r_gain_fire <= w_gain_tick[PW];
                r_key_tick  <= w_key_tick[PW-1:0];
                if (w_key_tick[PW]) begin
                    if (r_key_in && !r_key_prev) begin
                        r_mode <= ~r_mode;
                    end
                    r_key_prev <= r_key_in;
                end
            end
            // block complete: sums go to the multiplier and restart
            if (i_cmd.avg_mul && r_avg_due) begin
                r_lvl_sum <= '0;
                r_aux_sum <= '0;
            end
            if (i_cmd.avg_latch && r_avg_due) begin
                r_lvl_avg <= r_lvl_prod[SH +: SW];
                r_aux_avg <= r_aux_prod[SH +: SW];
            end
            if (i_cmd.gain_wr) begin
                r_gain_code <= w_code_sat;
            end
        end
    end

    // arithmetic and request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lvl_in <= i_level_sample;
            r_aux_in <= i_aux_sample;
            r_key_in <= i_key_pressed;
        end
        if (i_cmd.avg_mul) begin
            r_lvl_prod <= PROD_W'(r_lvl_sum) * PROD_W'(RECIP);
            r_aux_prod <= PROD_W'(r_aux_sum) * PROD_W'(RECIP);
        end
        if (i_cmd.gain_mul) begin
            r_gprod <= GP_W'(r_gain_slope) * GP_W'(r_lvl_avg);
        end
        if (i_cmd.den_load) begin
            r_den <= DW'(r_gprod) + DW'(r_gain_offset);
            r_rem <= '0;
            r_quo <= r_gain_num;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_fits ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_quo <= {r_quo[NW-2:0], w_fits};
        end
        if (i_cmd.commit) begin
            r_out_lvl      <= r_lvl_avg;
            r_out_aux      <= r_aux_avg;
            r_out_mode     <= r_mode;
            r_out_code     <= r_gain_code;
            r_out_gain_upd <= r_gain_fire;
            r_out_rep      <= r_rep_fire;
        end
    end

    assign o_level_average = r_out_lvl;
    assign o_aux_average   = r_out_aux;
    assign o_mode          = r_out_mode;
    assign o_gain_code     = r_out_code;
    assign o_gain_update   = r_out_gain_upd;
    assign o_report_strobe = r_out_rep;

endmodule

### rtl/core/agc_average_and_gain_code_core.sv
// agc_average_and_gain_code_core: top level of the agc core, joins the
// sequencer and the datapath; depends on agc_pkg, agc_ctrl and agc_dp
//
// usage
// - one input request is one 5 ms tick: level and aux converter samples plus
//   the key level, taken when i_in_valid and o_in_ready are both high
// - each tick gives exactly one result request: latest block averages, mode,
//   gain code, a gain update flag and a report strobe
// - o_in_ready is high only while the sequencer is idle; one tick is worked
//   on at a time
// - from input accept to o_out_valid a plain tick runs the accumulate,
//   average multiply, average latch and commit steps; a gain tick adds
//   gain multiply, denominator load, the restoring divider at one quotient
//   bit per cycle and gain code write; o_in_ready rises with o_out_valid
// - the result sits in an output register: a stalled receiver does not block
//   the next input accept, but the following result waits until the
//   register is taken
// - configuration writes are always accepted (o_cfg_ready high) and must be
//   made while the core is idle; an index beyond the list is ignored
// - synchronous active-low reset returns all registers to their defaults
//   and clears sums, counters, averages, mode and gain code
module agc_average_and_gain_code_core #(
    parameter int SAMPLES_PER_AVERAGE = agc_pkg::SAMPLES_PER_AVERAGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [agc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [agc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // tick input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [agc_pkg::SAMPLE_W-1:0]     i_level_sample,
    input  logic [agc_pkg::SAMPLE_W-1:0]     i_aux_sample,
    input  logic                             i_key_pressed,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [agc_pkg::SAMPLE_W-1:0]     o_level_average,
    output logic [agc_pkg::SAMPLE_W-1:0]     o_aux_average,
    output logic                             o_mode,
    output logic [agc_pkg::CODE_W-1:0]       o_gain_code,
    output logic                             o_gain_update,
    output logic                             o_report_strobe
);

    agc_pkg::t_cmd     w_cmd;
    agc_pkg::t_status  w_status;

    // registers are plain flops, a write never has to wait
    assign o_cfg_ready = 1'b1;

    // sequencer: a state per datapath step, 27 divider steps share one state
    agc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: sums, counters, multipliers, divider and the result register
    agc_dp #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_level_sample  (i_level_sample),
        .i_aux_sample    (i_aux_sample),
        .i_key_pressed   (i_key_pressed),
        .o_level_average (o_level_average),
        .o_aux_average   (o_aux_average),
        .o_mode          (o_mode),
        .o_gain_code     (o_gain_code),
        .o_gain_update   (o_gain_update),
        .o_report_strobe (o_report_strobe)
    );

`ifndef NO_ASSERTIONS
    // a taken tick makes the core busy on the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready right after a tick was accepted");

    // the sequencer drives at most one datapath step per cycle
    a_one_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // the divider only runs on a gain tick
    a_div_on_gain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> w_status.gain_fire)
        else $error("divider stepping without a gain event");
`endif

endmodule

### dv/agc_average_and_gain_code_core_test.sv
// agc_average_and_gain_code_core_test: self-checking bench for the agc core,
// with its own tick predictor in a small scoreboard class and plain driving tasks
// depends on agc_pkg and agc_average_and_gain_code_core
`timescale 1ns / 1ps

module agc_average_and_gain_code_core_test;

    localparam int SAMPLES     = agc_pkg::SAMPLES_PER_AVERAGE_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    // indexes past the register list, the core must ignore them
    localparam logic [agc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [agc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // one result request as the core presents it
    typedef struct packed {
        logic [agc_pkg::SAMPLE_W-1:0] level_average;
        logic [agc_pkg::SAMPLE_W-1:0] aux_average;
        logic                         mode;
        logic [agc_pkg::CODE_W-1:0]   gain_code;
        logic                         gain_update;
        logic                         report_strobe;
    } t_tick_result;

    // tick predictor: own copy of the registers and of the core state, plus
    // the queue of results still owed by the core
    class t_tick_scoreboard;
        bit [agc_pkg::PERIOD_W-1:0] key_period, gain_period, report_period;
        bit [agc_pkg::NUM_W-1:0]    numerator;
        bit [agc_pkg::SLOPE_W-1:0]  slope;
        bit [agc_pkg::OFFSET_W-1:0] offset;

        bit [13:0]                  level_sum, aux_sum;
        int                         sample_count;
        bit [agc_pkg::SAMPLE_W-1:0] level_avg, aux_avg;
        bit [agc_pkg::PERIOD_W-1:0] key_ticks, gain_ticks, report_ticks;
        bit                         key_prev, mode;
        bit [agc_pkg::CODE_W-1:0]   code;

        t_tick_result               results_due[$];
        int                         error_count;

        function new();
            key_period    = agc_pkg::KEY_PERIOD_RST;
            gain_period   = agc_pkg::GAIN_PERIOD_RST;
            report_period = agc_pkg::REPORT_PERIOD_RST;
            numerator     = agc_pkg::GAIN_NUM_RST;
            slope         = agc_pkg::GAIN_SLOPE_RST;
            offset        = agc_pkg::GAIN_OFFSET_RST;
            level_sum     = '0;
            aux_sum       = '0;
            sample_count  = 0;
            level_avg     = '0;
            aux_avg       = '0;
            key_ticks     = '0;
            gain_ticks    = '0;
            report_ticks  = '0;
            key_prev      = 1'b0;
            mode          = 1'b0;
            code          = '0;
            error_count   = 0;
        endfunction

        function void write_register(bit [agc_pkg::CFG_IDX_W-1:0] idx,
                                     bit [agc_pkg::CFG_DATA_W-1:0] data);
            unique case (idx)
                agc_pkg::CFG_KEY_PERIOD:    key_period    = data[agc_pkg::PERIOD_W-1:0];
                agc_pkg::CFG_GAIN_PERIOD:   gain_period   = data[agc_pkg::PERIOD_W-1:0];
                agc_pkg::CFG_REPORT_PERIOD: report_period = data[agc_pkg::PERIOD_W-1:0];
                agc_pkg::CFG_GAIN_NUM:      numerator     = data[agc_pkg::NUM_W-1:0];
                agc_pkg::CFG_GAIN_SLOPE:    slope         = data[agc_pkg::SLOPE_W-1:0];
                agc_pkg::CFG_GAIN_OFFSET:   offset        = data[agc_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // counter step: a period below the count (or zero) fires at once
        function bit period_due(inout bit [agc_pkg::PERIOD_W-1:0] ticks,
                                input bit [agc_pkg::PERIOD_W-1:0] period);
            bit [agc_pkg::PERIOD_W:0] nxt;
            nxt = {1'b0, ticks} + 1'b1;
            if (nxt >= {1'b0, period}) begin
                ticks = '0;
                return 1'b1;
            end
            ticks = nxt[agc_pkg::PERIOD_W-1:0];
            return 1'b0;
        endfunction

        function bit [agc_pkg::CODE_W-1:0] gain_for(bit [agc_pkg::SAMPLE_W-1:0] avg);
            longint unsigned den, quo;
            den = longint'(slope) * longint'(avg) + longint'(offset);
            if (den == 0)
                return agc_pkg::CODE_MAX;
            quo = longint'(numerator) / den;
            return (quo > agc_pkg::CODE_MAX) ? agc_pkg::CODE_MAX : quo[agc_pkg::CODE_W-1:0];
        endfunction

        function void accept_tick(bit [agc_pkg::SAMPLE_W-1:0] lvl,
                                  bit [agc_pkg::SAMPLE_W-1:0] aux, bit key);
            t_tick_result res;
            bit gain_due, report_due;
            level_sum = level_sum + 14'(lvl);
            aux_sum   = aux_sum + 14'(aux);
            sample_count++;
            if (sample_count >= SAMPLES) begin
                level_avg    = agc_pkg::SAMPLE_W'(level_sum / SAMPLES);
                aux_avg      = agc_pkg::SAMPLE_W'(aux_sum / SAMPLES);
                level_sum    = '0;
                aux_sum      = '0;
                sample_count = 0;
            end
            report_due = period_due(report_ticks, report_period);
            gain_due   = period_due(gain_ticks, gain_period);
            if (period_due(key_ticks, key_period)) begin
                if (key && !key_prev)
                    mode = ~mode;
                key_prev = key;
            end
            if (gain_due)
                code = gain_for(level_avg);
            res.level_average = level_avg;
            res.aux_average   = aux_avg;
            res.mode          = mode;
            res.gain_code     = code;
            res.gain_update   = gain_due;
            res.report_strobe = report_due;
            results_due.push_back(res);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                error_count++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_tick_result got);
            t_tick_result want;
            if (results_due.size() == 0) begin
                error_count++;
                $display("%0t: result expected none, actual %h", $time, got);
                return;
            end
            want = results_due.pop_front();
            compare_field("level_average", want.level_average, got.level_average);
            compare_field("aux_average", want.aux_average, got.aux_average);
            compare_field("mode", want.mode, got.mode);
            compare_field("gain_code", want.gain_code, got.gain_code);
            compare_field("gain_update", want.gain_update, got.gain_update);
            compare_field("report_strobe", want.report_strobe, got.report_strobe);
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    // block ports, the inputs driven to known values from time zero
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [agc_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [agc_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [agc_pkg::SAMPLE_W-1:0]   i_level_sample = '0;
    logic [agc_pkg::SAMPLE_W-1:0]   i_aux_sample = '0;
    logic                           i_key_pressed = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [agc_pkg::SAMPLE_W-1:0]   o_level_average;
    logic [agc_pkg::SAMPLE_W-1:0]   o_aux_average;
    logic                           o_mode;
    logic [agc_pkg::CODE_W-1:0]     o_gain_code;
    logic                           o_gain_update;
    logic                           o_report_strobe;

    t_tick_scoreboard tick_board = new();

    // idling odds in percent per cycle, set between phases
    int in_idle_pct  = 0;
    int out_idle_pct = 0;

    // long receiver hold-off: bumping hold_seq asks for one
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // key level held for random runs so that press edges land on samples
    logic key_level    = 1'b0;
    int   key_run_left = 0;

    agc_average_and_gain_code_core #(
        .SAMPLES_PER_AVERAGE(SAMPLES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_level_sample (i_level_sample),
        .i_aux_sample   (i_aux_sample),
        .i_key_pressed  (i_key_pressed),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_level_average(o_level_average),
        .o_aux_average  (o_aux_average),
        .o_mode         (o_mode),
        .o_gain_code    (o_gain_code),
        .o_gain_update  (o_gain_update),
        .o_report_strobe(o_report_strobe)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("agc_average_and_gain_code_core_test: done, errors");
        $finish;
    end

    // receiver: check each accepted result, then pick next cycle's ready;
    // a hold-off request wins over the random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tick_board.check_result({o_level_average, o_aux_average, o_mode,
                                     o_gain_code, o_gain_update, o_report_strobe});
        end
        if (hold_seen != hold_seq) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // one register write; cfg valid stays up across a burst of writes
    task automatic write_register(input logic [agc_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [agc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tick_board.write_register(idx, data);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
    endtask

    // offer one tick request, with a random sender gap in front of it
    task automatic offer_tick(input logic [agc_pkg::SAMPLE_W-1:0] lvl,
                              input logic [agc_pkg::SAMPLE_W-1:0] aux,
                              input logic key);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_level_sample <= lvl;
        i_aux_sample   <= aux;
        i_key_pressed  <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tick_board.accept_tick(lvl, aux, key);
    endtask

    // stop offering and wait for every owed result and an idle core
    task automatic pause_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tick_board.pending() != 0) @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [agc_pkg::SAMPLE_W-1:0] pick_sample();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return agc_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // random ticks; with pressure the receiver holds off early on and the
    // sender later waits for the core to drain completely
    task automatic run_random(input int n_items, input bit with_pressure);
        for (int k = 0; k < n_items; k++) begin
            if (with_pressure && k == 20)
                hold_seq++;
            if (with_pressure && k == n_items / 2)
                pause_input();
            if (key_run_left == 0) begin
                key_level    = ~key_level;
                key_run_left = $urandom_range(1, 12);
            end
            key_run_left--;
            offer_tick(pick_sample(), pick_sample(), key_level);
        end
        pause_input();
    endtask

    task automatic set_periods(input int key_p, input int gain_p, input int report_p);
        write_register(agc_pkg::CFG_KEY_PERIOD, agc_pkg::CFG_DATA_W'(key_p));
        write_register(agc_pkg::CFG_GAIN_PERIOD, agc_pkg::CFG_DATA_W'(gain_p));
        write_register(agc_pkg::CFG_REPORT_PERIOD, agc_pkg::CFG_DATA_W'(report_p));
    endtask

    task automatic set_gain(input int unsigned num, input int unsigned slp,
                            input int unsigned ofs);
        write_register(agc_pkg::CFG_GAIN_NUM, agc_pkg::CFG_DATA_W'(num));
        write_register(agc_pkg::CFG_GAIN_SLOPE, agc_pkg::CFG_DATA_W'(slp));
        write_register(agc_pkg::CFG_GAIN_OFFSET, agc_pkg::CFG_DATA_W'(ofs));
    endtask

    initial begin
        // sender idles lightly, receiver heavily
        in_idle_pct  = 17;
        out_idle_pct = 67;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);

        // directed: key and gain events on every tick, widest numerator over
        // a tiny zero-average denominator: the code saturates, spares ignored
        set_periods(1, 1, 3);
        set_gain(27'h7FF_FFFF, 16'hFFFF, 1);
        write_register(CFG_SPARE_LO, agc_pkg::CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_HI, '1);
        end_writes();
        // full-scale samples with the key bouncing, mode toggles on presses
        for (int i = 0; i < 10; i++)
            offer_tick('1, '1, (i % 2) == 0);
        pause_input();

        // zero denominator through zero slope and zero offset, zero gain
        // period, key period written with junk above its width
        set_gain(27'h7FF_FFFF, 0, 0);
        write_register(agc_pkg::CFG_KEY_PERIOD, 27'h7FF_0002);
        write_register(agc_pkg::CFG_GAIN_PERIOD, '0);
        end_writes();
        for (int i = 0; i < 4; i++)
            offer_tick('0, agc_pkg::SAMPLE_W'($urandom), 1'b1);
        pause_input();

        // widest slope, zero offset: denominator goes to zero once the
        // zero-sample block average lands
        write_register(agc_pkg::CFG_GAIN_SLOPE, agc_pkg::CFG_DATA_W'(16'hFFFF));
        end_writes();
        for (int i = 0; i < 10; i++)
            offer_tick('0, agc_pkg::SAMPLE_W'($urandom), i[1]);
        pause_input();

        // reset values written back explicitly
        set_periods(agc_pkg::KEY_PERIOD_RST, agc_pkg::GAIN_PERIOD_RST,
                    agc_pkg::REPORT_PERIOD_RST);
        set_gain(agc_pkg::GAIN_NUM_RST, agc_pkg::GAIN_SLOPE_RST, agc_pkg::GAIN_OFFSET_RST);
        end_writes();
        run_random(250, 1'b0);

        // every event on every tick, random gain constants
        set_periods(1, 1, 1);
        set_gain($urandom_range(0, 27'h7FF_FFFF), $urandom_range(0, 16'hFFFF),
                 $urandom_range(1, 20'hF_FFFF));
        end_writes();
        run_random(150, 1'b0);

        // roles of the two sides swapped
        in_idle_pct  = 67;
        out_idle_pct = 17;
        set_periods(16'hFFFF, 16'hFFFF, 16'hFFFF);
        end_writes();
        run_random(100, 1'b0);

        // periods dropped below the running counts, zero numerator,
        // widest offset; long receiver hold-off and a sender pause
        set_periods(2, 3, 4);
        set_gain(0, 0, 20'hF_FFFF);
        end_writes();
        run_random(150, 1'b1);

        // no idling on either side
        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int s = 0; s < 4; s++) begin
            set_periods($urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(1, 16));
            set_gain($urandom_range(0, 27'h7FF_FFFF), $urandom_range(0, 16'hFFFF),
                     $urandom_range(0, 20'hF_FFFF));
            end_writes();
            run_random(50, 1'b0);
        end

        // zero periods fire every tick; widest numerator and slope
        set_periods(0, 0, 0);
        set_gain(27'h7FF_FFFF, 16'hFFFF, 1);
        end_writes();
        run_random(150, 1'b0);

        // let any stray result show up before judging
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tick_board.error_count == 0 && tick_board.pending() == 0) begin
            $display("agc_average_and_gain_code_core_test: done, clean");
        end else begin
            $display("agc_average_and_gain_code_core_test: done, errors");
        end
        $finish;
    end

endmodule
